### design/assert_macros.svh
// Assertion macros shared by the joystick direction event design.
// No dependencies; files that assert include this header by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/jde_pkg.sv
// Types, constants and helper functions for the joystick direction event block.
// No dependencies; used by joystick_direction_event.
package jde_pkg;

	localparam int unsigned AXIS_W    = 12;
	localparam int unsigned HOLDOFF_W = 16;
	localparam int unsigned CMD_W     = 8;
	localparam int unsigned OUT_DIR_W = 2;
	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned DATA_W    = 32;

	typedef enum logic [2:0] {
		DIR_CENTER = 3'd0,
		DIR_UP     = 3'd1,
		DIR_DOWN   = 3'd2,
		DIR_LEFT   = 3'd3,
		DIR_RIGHT  = 3'd4
	} dir_t;

	typedef enum logic [2:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_DEADZONE_X = 3'd2,
		REG_DEADZONE_Y = 3'd3,
		REG_MOVE_X     = 3'd4,
		REG_MOVE_Y     = 3'd5,
		REG_HOLDOFF    = 3'd6
	} reg_idx_t;

	localparam logic [0:0] REQ_SAMPLE = 1'b0;
	localparam logic [0:0] REQ_TICK   = 1'b1;

	localparam logic [OUT_DIR_W-1:0] OUT_UP    = 2'd0;
	localparam logic [OUT_DIR_W-1:0] OUT_DOWN  = 2'd1;
	localparam logic [OUT_DIR_W-1:0] OUT_LEFT  = 2'd2;
	localparam logic [OUT_DIR_W-1:0] OUT_RIGHT = 2'd3;

	localparam logic [CMD_W-1:0] CMD_UP    = 8'h11;
	localparam logic [CMD_W-1:0] CMD_DOWN  = 8'h10;
	localparam logic [CMD_W-1:0] CMD_LEFT  = 8'h14;
	localparam logic [CMD_W-1:0] CMD_RIGHT = 8'h13;

	localparam logic [AXIS_W-1:0]    CENTER_X_RST   = 12'd2055;
	localparam logic [AXIS_W-1:0]    CENTER_Y_RST   = 12'd2050;
	localparam logic [AXIS_W-1:0]    DEADZONE_RST   = 12'd400;
	localparam logic [AXIS_W-1:0]    MOVE_RST       = 12'd1200;
	localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST    = 16'd100;
	localparam logic [HOLDOFF_W-1:0] ELAPSED_MAX    = 16'hFFFF;

	function automatic logic [OUT_DIR_W-1:0] out_code_of(dir_t d);
		logic [OUT_DIR_W-1:0] code;
		case (d)
			DIR_UP:   code = OUT_UP;
			DIR_DOWN: code = OUT_DOWN;
			DIR_LEFT: code = OUT_LEFT;
			default:  code = OUT_RIGHT;
		endcase
		return code;
	endfunction

	function automatic logic [CMD_W-1:0] cmd_of(logic [OUT_DIR_W-1:0] code);
		logic [CMD_W-1:0] cmd;
		case (code)
			OUT_UP:   cmd = CMD_UP;
			OUT_DOWN: cmd = CMD_DOWN;
			OUT_LEFT: cmd = CMD_LEFT;
			default:  cmd = CMD_RIGHT;
		endcase
		return cmd;
	endfunction

endpackage

### design/joystick_direction_event.sv
// Joystick direction event block: classifies stick samples and emits direction commands.
// Depends on jde_pkg and on assert_macros.svh.
//
// Input items arrive on the s_ channel: tuser says whether the item is a position
// sample or a one-millisecond tick, tdata carries the X and Y readings. Result items
// leave on the m_ channel and carry the new direction and its command byte. Only a
// sample that moves the stick to a new non-centre direction outside the hold-off
// window yields a result; ticks and all other samples yield none.
// An accepted item sits in the input register, where it is evaluated against the stored
// direction and elapsed-time counter; its result is loaded into the result register and
// is presented on the m_ channel from there.
// One item is accepted per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its item, the input register
// fills, and s_tready falls until the result is taken.
// Reset clears the stored direction to centre, the elapsed counter to zero and loads
// the register defaults, so samples are ignored until the hold-off has run out.
// The APB port sets the thresholds; it should only be written while the block is idle.
`include "assert_macros.svh"

module joystick_direction_event (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [jde_pkg::ADDR_W-1:0]      paddr,
	input  logic [jde_pkg::DATA_W-1:0]      pwdata,
	output logic [jde_pkg::DATA_W-1:0]      prdata,
	output logic                            pready,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [23:0]                     s_tdata,  // x_sample [11:0], y_sample [23:12]
	input  logic                            s_tuser,  // req_type [0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata   // direction [1:0], command_byte [9:2]
);

	logic [jde_pkg::AXIS_W-1:0]    center_x_q;
	logic [jde_pkg::AXIS_W-1:0]    center_y_q;
	logic [jde_pkg::AXIS_W-1:0]    deadzone_x_q;
	logic [jde_pkg::AXIS_W-1:0]    deadzone_y_q;
	logic [jde_pkg::AXIS_W-1:0]    move_x_q;
	logic [jde_pkg::AXIS_W-1:0]    move_y_q;
	logic [jde_pkg::HOLDOFF_W-1:0] holdoff_q;

	jde_pkg::reg_idx_t reg_idx;
	logic              cfg_write;

	logic                         valid_s1;
	logic                         req_s1;
	logic [jde_pkg::AXIS_W-1:0]   x_s1;
	logic [jde_pkg::AXIS_W-1:0]   y_s1;

	jde_pkg::dir_t                 last_dir_q;
	logic [jde_pkg::HOLDOFF_W-1:0] elapsed_q;

	logic                            out_valid_q;
	logic [jde_pkg::OUT_DIR_W-1:0]   out_dir_q;
	logic [jde_pkg::CMD_W-1:0]       out_cmd_q;

	logic signed [jde_pkg::AXIS_W:0] dx;
	logic signed [jde_pkg::AXIS_W:0] dy;
	logic [jde_pkg::AXIS_W-1:0]      ax;
	logic [jde_pkg::AXIS_W-1:0]      ay;
	jde_pkg::dir_t                   cls;
	logic                            advance;
	logic                            is_sample;
	logic                            open_window;
	logic                            dir_change;
	logic                            emit;
	logic [jde_pkg::OUT_DIR_W-1:0]   new_dir_code;

	// Configuration port.
	assign pready    = 1'b1;
	assign reg_idx   = jde_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q   <= jde_pkg::CENTER_X_RST;
			center_y_q   <= jde_pkg::CENTER_Y_RST;
			deadzone_x_q <= jde_pkg::DEADZONE_RST;
			deadzone_y_q <= jde_pkg::DEADZONE_RST;
			move_x_q     <= jde_pkg::MOVE_RST;
			move_y_q     <= jde_pkg::MOVE_RST;
			holdoff_q    <= jde_pkg::HOLDOFF_RST;
		end else if (cfg_write) begin
			case (reg_idx)
				jde_pkg::REG_CENTER_X:   center_x_q   <= pwdata[jde_pkg::AXIS_W-1:0];
				jde_pkg::REG_CENTER_Y:   center_y_q   <= pwdata[jde_pkg::AXIS_W-1:0];
				jde_pkg::REG_DEADZONE_X: deadzone_x_q <= pwdata[jde_pkg::AXIS_W-1:0];
				jde_pkg::REG_DEADZONE_Y: deadzone_y_q <= pwdata[jde_pkg::AXIS_W-1:0];
				jde_pkg::REG_MOVE_X:     move_x_q     <= pwdata[jde_pkg::AXIS_W-1:0];
				jde_pkg::REG_MOVE_Y:     move_y_q     <= pwdata[jde_pkg::AXIS_W-1:0];
				jde_pkg::REG_HOLDOFF:    holdoff_q    <= pwdata[jde_pkg::HOLDOFF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			jde_pkg::REG_CENTER_X:   prdata = {20'd0, center_x_q};
			jde_pkg::REG_CENTER_Y:   prdata = {20'd0, center_y_q};
			jde_pkg::REG_DEADZONE_X: prdata = {20'd0, deadzone_x_q};
			jde_pkg::REG_DEADZONE_Y: prdata = {20'd0, deadzone_y_q};
			jde_pkg::REG_MOVE_X:     prdata = {20'd0, move_x_q};
			jde_pkg::REG_MOVE_Y:     prdata = {20'd0, move_y_q};
			jde_pkg::REG_HOLDOFF:    prdata = {16'd0, holdoff_q};
			default:                 prdata = '0;
		endcase
	end

	// Input register.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1 <= s_tuser;
			x_s1   <= s_tdata[11:0];
			y_s1   <= s_tdata[23:12];
		end
	end

	// Classification of the held sample.
	always_comb begin
		dx = $signed({1'b0, x_s1}) - $signed({1'b0, center_x_q});
		dy = $signed({1'b0, y_s1}) - $signed({1'b0, center_y_q});
		ax = dx[jde_pkg::AXIS_W] ? jde_pkg::AXIS_W'(-dx) : dx[jde_pkg::AXIS_W-1:0];
		ay = dy[jde_pkg::AXIS_W] ? jde_pkg::AXIS_W'(-dy) : dy[jde_pkg::AXIS_W-1:0];
		cls = jde_pkg::DIR_CENTER;
		if (ax < deadzone_x_q && ay < deadzone_y_q) begin
			cls = jde_pkg::DIR_CENTER;
		end else if (ax > ay) begin
			if (ax > move_x_q) begin
				cls = dx[jde_pkg::AXIS_W] ? jde_pkg::DIR_LEFT : jde_pkg::DIR_RIGHT;
			end
		end else begin
			if (ay > move_y_q) begin
				cls = dy[jde_pkg::AXIS_W] ? jde_pkg::DIR_DOWN : jde_pkg::DIR_UP;
			end
		end
	end

	assign is_sample    = (req_s1 == jde_pkg::REQ_SAMPLE);
	assign open_window  = (elapsed_q >= holdoff_q);
	assign dir_change   = is_sample && open_window && (cls != last_dir_q);
	assign emit         = dir_change && (cls != jde_pkg::DIR_CENTER);
	assign new_dir_code = jde_pkg::out_code_of(cls);

	// Direction and hold-off state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_dir_q <= jde_pkg::DIR_CENTER;
			elapsed_q  <= '0;
		end else if (advance) begin
			if (req_s1 == jde_pkg::REQ_TICK) begin
				if (elapsed_q != jde_pkg::ELAPSED_MAX) begin
					elapsed_q <= elapsed_q + 1'b1;
				end
			end else if (dir_change) begin
				last_dir_q <= cls;
				if (emit) begin
					elapsed_q <= '0;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_dir_q <= new_dir_code;
			out_cmd_q <= jde_pkg::cmd_of(new_dir_code);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_cmd_q, out_dir_q};

	`ASSERT_NEXT(a_holdoff_restart, advance && emit, elapsed_q == '0, "hold-off not restarted")
	`ASSERT_NEXT(a_result_loaded, advance && emit, out_valid_q, "result item lost")
	`ASSERT_NEXT(a_dir_stored, advance && emit, last_dir_q != jde_pkg::DIR_CENTER, "direction not stored")
	`ASSERT_IMPLY(a_stall_cause, !s_tready, valid_s1 && out_valid_q && !m_tready, "needless stall")
	`ASSERT_IMPLY(a_cmd_match, out_valid_q, out_cmd_q == jde_pkg::cmd_of(out_dir_q), "bad command byte")

endmodule

### tb/jde_event_checker.sv
// Checker for the joystick direction event block: follows the APB writes and both streams.
// It predicts the direction events and compares every result item with the oldest one due.
// Depends on jde_pkg.
module jde_event_checker
	import jde_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [23:0]       s_tdata,  // x_sample [11:0], y_sample [23:12]
	input  logic              s_tuser,  // req_type [0]
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [15:0]       m_tdata,  // direction [1:0], command_byte [9:2]
	output int                fault_count,
	output int                events_due
);

	typedef struct packed {
		logic [OUT_DIR_W-1:0] dir;
		logic [CMD_W-1:0]     cmd;
	} stick_event_t;

	stick_event_t         pending_events[$];
	logic [AXIS_W-1:0]    ctr_x, ctr_y, dz_x, dz_y, mv_x, mv_y;
	logic [HOLDOFF_W-1:0] holdoff, ms_since_event;
	dir_t                 stick_dir;
	int                   faults;

	function automatic dir_t classify_stick(logic [AXIS_W-1:0] x, logic [AXIS_W-1:0] y);
		int dx, dy, ax, ay;
		dx = int'(x) - int'(ctr_x);
		dy = int'(y) - int'(ctr_y);
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		if (ax < int'(dz_x) && ay < int'(dz_y))
			return DIR_CENTER;
		if (ax > ay) begin
			if (dx > int'(mv_x))
				return DIR_RIGHT;
			if (dx < -int'(mv_x))
				return DIR_LEFT;
		end else begin
			if (dy > int'(mv_y))
				return DIR_UP;
			if (dy < -int'(mv_y))
				return DIR_DOWN;
		end
		return DIR_CENTER;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stick_event_t got, ev;
		dir_t         cls;
		if (!arst_n) begin
			ctr_x = CENTER_X_RST;
			ctr_y = CENTER_Y_RST;
			dz_x = DEADZONE_RST;
			dz_y = DEADZONE_RST;
			mv_x = MOVE_RST;
			mv_y = MOVE_RST;
			holdoff = HOLDOFF_RST;
			ms_since_event = '0;
			stick_dir = DIR_CENTER;
			pending_events.delete();
			faults = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_CENTER_X:   ctr_x = pwdata[AXIS_W-1:0];
					REG_CENTER_Y:   ctr_y = pwdata[AXIS_W-1:0];
					REG_DEADZONE_X: dz_x = pwdata[AXIS_W-1:0];
					REG_DEADZONE_Y: dz_y = pwdata[AXIS_W-1:0];
					REG_MOVE_X:     mv_x = pwdata[AXIS_W-1:0];
					REG_MOVE_Y:     mv_y = pwdata[AXIS_W-1:0];
					REG_HOLDOFF:    holdoff = pwdata[HOLDOFF_W-1:0];
					default:        ;
				endcase
			end

			if (m_tvalid && m_tready) begin
				got.dir = m_tdata[OUT_DIR_W-1:0];
				got.cmd = m_tdata[OUT_DIR_W +: CMD_W];
				if (pending_events.size() == 0) begin
					$error("unexpected result item: direction %0d, command_byte %h",
						got.dir, got.cmd);
					faults++;
				end else begin
					ev = pending_events.pop_front();
					if (got.dir !== ev.dir) begin
						$error("direction: expected %0d, actual %0d", ev.dir, got.dir);
						faults++;
					end
					if (got.cmd !== ev.cmd) begin
						$error("command_byte: expected %h, actual %h", ev.cmd, got.cmd);
						faults++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				if (s_tuser == REQ_TICK) begin
					if (ms_since_event != ELAPSED_MAX)
						ms_since_event++;
				end else if (ms_since_event >= holdoff) begin
					cls = classify_stick(s_tdata[AXIS_W-1:0], s_tdata[AXIS_W +: AXIS_W]);
					if (cls != stick_dir) begin
						stick_dir = cls;
						// Returning to centre neither reports nor restarts the hold-off.
						if (cls != DIR_CENTER) begin
							case (cls)
								DIR_UP: begin
									ev.dir = OUT_UP;
									ev.cmd = CMD_UP;
								end
								DIR_DOWN: begin
									ev.dir = OUT_DOWN;
									ev.cmd = CMD_DOWN;
								end
								DIR_LEFT: begin
									ev.dir = OUT_LEFT;
									ev.cmd = CMD_LEFT;
								end
								default: begin
									ev.dir = OUT_RIGHT;
									ev.cmd = CMD_RIGHT;
								end
							endcase
							pending_events.push_back(ev);
							ms_since_event = '0;
						end
					end
				end
			end
		end
		fault_count <= faults;
		events_due <= pending_events.size();
	end

endmodule

### tb/tb.sv
// Top of the joystick direction event testbench: clock, reset, register set-up and stimulus.
// Depends on jde_pkg, joystick_direction_event and jde_event_checker, which judges the results.
module tb;
	import jde_pkg::*;

	localparam int                SETTLE      = 6;
	localparam int                QUIET_LIMIT = 2000;
	localparam logic [2:0]        REG_UNUSED  = 3'd7;
	localparam logic [AXIS_W-1:0] AXIS_MAX    = '1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [23:0]       s_tdata = '0;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;
	int                fault_count;
	int                events_due;
	int                quiet_cycles = 0;
	bit                calm = 1'b0;
	logic [AXIS_W-1:0] rest_x = CENTER_X_RST;
	logic [AXIS_W-1:0] rest_y = CENTER_Y_RST;

	joystick_direction_event dut (.*);
	jde_event_checker event_check (.*);

	always #4 clk = ~clk;

	always @(posedge clk)
		m_tready <= calm || $urandom_range(0, 99) >= 11;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic put_item(logic req, logic [AXIS_W-1:0] x, logic [AXIS_W-1:0] y);
		while (!calm && $urandom_range(0, 99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {y, x};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic tick_ms(int n);
		repeat (n) put_item(REQ_TICK, AXIS_W'($urandom_range(0, 4095)),
			AXIS_W'($urandom_range(0, 4095)));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (events_due != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int unsigned value);
		int unsigned w;
		w = (idx == REG_HOLDOFF) ? HOLDOFF_W : AXIS_W;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		// Junk above the register width must be dropped by the block.
		pwdata <= ($urandom << w) | value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_config(int unsigned cx, int unsigned cy, int unsigned dzx,
			int unsigned dzy, int unsigned mvx, int unsigned mvy, int unsigned hold);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_DEADZONE_X, dzx);
		write_reg(REG_DEADZONE_Y, dzy);
		write_reg(REG_MOVE_X, mvx);
		write_reg(REG_MOVE_Y, mvy);
		write_reg(REG_HOLDOFF, hold);
		write_reg(REG_UNUSED, $urandom_range(0, 4095));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		rest_x = AXIS_W'(cx);
		rest_y = AXIS_W'(cy);
	endtask

	function automatic logic [AXIS_W-1:0] near(logic [AXIS_W-1:0] rest);
		int v;
		v = int'($urandom_range(0, 3200)) - 1600 + int'(rest);
		if (v < 0)
			return '0;
		if (v > int'(AXIS_MAX))
			return AXIS_MAX;
		return v[AXIS_W-1:0];
	endfunction

	task automatic random_items(int n, bit pause_midway);
		for (int i = 0; i < n; i++) begin
			if (pause_midway && i == n / 2)
				wait_idle();
			if ($urandom_range(0, 99) < 35)
				tick_ms(1);
			else if ($urandom_range(0, 3) == 0)
				put_item(REQ_SAMPLE, AXIS_W'($urandom_range(0, 4095)),
					AXIS_W'($urandom_range(0, 4095)));
			else
				put_item(REQ_SAMPLE, near(rest_x), near(rest_y));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The counter starts at zero, so these samples fall inside the start-up hold-off.
		put_item(REQ_SAMPLE, AXIS_MAX, CENTER_Y_RST);
		tick_ms(1);
		put_item(REQ_SAMPLE, '0, CENTER_Y_RST);
		wait_idle();

		set_config(32'(CENTER_X_RST), 32'(CENTER_Y_RST), 32'(DEADZONE_RST),
			32'(DEADZONE_RST), 32'(MOVE_RST), 32'(MOVE_RST), 3);
		tick_ms(2);
		put_item(REQ_SAMPLE, AXIS_MAX, CENTER_Y_RST);
		tick_ms(3);
		put_item(REQ_SAMPLE, AXIS_MAX, CENTER_Y_RST);
		put_item(REQ_SAMPLE, CENTER_X_RST, CENTER_Y_RST);
		put_item(REQ_SAMPLE, CENTER_X_RST, AXIS_MAX);
		put_item(REQ_SAMPLE, '0, AXIS_MAX);
		tick_ms(3);
		put_item(REQ_SAMPLE, CENTER_X_RST, '0);
		tick_ms(3);
		put_item(REQ_SAMPLE, '0, '0);
		tick_ms(3);
		put_item(REQ_SAMPLE, 12'd3555, 12'd3550);
		tick_ms(3);
		put_item(REQ_SAMPLE, 12'd2955, CENTER_Y_RST);
		wait_idle();

		set_config(32'(CENTER_X_RST), 32'(CENTER_Y_RST), 32'(DEADZONE_RST),
			32'(DEADZONE_RST), 32'(MOVE_RST), 32'(MOVE_RST), 2);
		random_items(150, 1'b1);
		wait_idle();

		set_config($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 800),
			$urandom_range(0, 800), $urandom_range(0, 1500), $urandom_range(0, 1500),
			$urandom_range(0, 6));
		random_items(150, 1'b0);
		wait_idle();

		calm = 1'b1;
		set_config(0, 0, 0, 0, 0, 0, 0);
		random_items(150, 1'b0);
		wait_idle();
		calm = 1'b0;

		set_config(32'(AXIS_MAX), 32'(AXIS_MAX), 32'(AXIS_MAX), 32'(AXIS_MAX), 0, 0, 1);
		random_items(150, 1'b0);
		wait_idle();

		set_config(32'(AXIS_MAX), 0, 0, 32'(AXIS_MAX), 32'(AXIS_MAX), 1000, 3);
		random_items(150, 1'b0);
		wait_idle();

		set_config($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 800),
			$urandom_range(0, 800), $urandom_range(0, 1500), $urandom_range(0, 1500),
			$urandom_range(0, 6));
		random_items(150, 1'b0);
		wait_idle();

		if (fault_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
